// ===== hdl/sllm_pkg.sv =====
// ----------------------------------------------------------------------------
// Static linked list manager package
// Shared payload types, operation and status codes, and sequencer states.
// ----------------------------------------------------------------------------
package sllm_pkg;

   localparam int POS_W   = 6;
   localparam int VALUE_W = 32;
   localparam int STAT_W  = 2;
   localparam int LEN_W   = 6;

   // Operation codes carried in the kind field.
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_DELETE = 1'b1;

   // Result status codes.
   localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_BAD_POS = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

   typedef struct packed {
      logic                      kind;
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] removed_value;
      logic [STAT_W-1:0]         status;
      logic [LEN_W-1:0]          list_length;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_FREE_HEAD,
      ST_FREE_NEXT,
      ST_WALK_START,
      ST_WALK,
      ST_INS_LINK,
      ST_INS_PREV,
      ST_DEL_UNLINK,
      ST_DEL_FREE_RD,
      ST_DEL_FREE_WR,
      ST_DEL_HEAD_WR,
      ST_DONE
   } state_type;

endpackage

// ===== hdl/sllm_ram.sv =====
// ----------------------------------------------------------------------------
// Single-port synchronous RAM
// One access per cycle at one address; read data is registered.
// ----------------------------------------------------------------------------
module sllm_ram
   import sllm_pkg::*;
#(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/static_linked_list_manager.sv =====
// ----------------------------------------------------------------------------
// Static linked list manager
// Array-backed linked list with a free chain and a used chain in one link RAM.
// ----------------------------------------------------------------------------
// The block keeps a list of up to LIST_SLOTS-2 signed 32-bit elements. Each
// item either inserts a value at a one-based position or deletes the element
// at a position and returns it; every item gives exactly one result with a
// status and the list length after the operation. Links live in a single-port
// link RAM whose slot 0 heads the free chain and whose last slot heads the
// used chain; values live in a separate element RAM. After reset the block
// runs a clearing pass that builds the free chain, and req_ready stays low
// until it ends. Items are handled one at a time. A rejected position goes
// from acceptance straight to the result state, and an insert into a full
// store first reads the free chain head. A valid insert or delete walks the
// used chain one link per cycle on the link RAM port, so its result comes
// later the further the position lies; the walk is what sets the rate. In
// every case the next item can be accepted in the same cycle that the result
// appears. A finished result waits in an output register, so the next item
// can be accepted while the previous result is still pending.
// ----------------------------------------------------------------------------
module static_linked_list_manager
   import sllm_pkg::*;
#(
   parameter int LIST_SLOTS = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   localparam int SW   = $clog2(LIST_SLOTS);
   localparam int CMPW = ((SW > POS_W) ? SW : POS_W) + 1;
   localparam logic [SW-1:0] FREE_HEAD = '0;
   localparam logic [SW-1:0] USED_HEAD = SW'(LIST_SLOTS - 1);
   localparam logic [SW-1:0] LAST_ELEM = SW'(LIST_SLOTS - 2);

   state_type state_ff, state_in;

   logic [SW-1:0]             init_cnt_ff, init_cnt_in;
   logic [SW-1:0]             count_ff, count_in;
   logic                      kind_ff, kind_in;
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [SW-1:0]             slot_ff, slot_in;
   logic [SW-1:0]             prev_ff, prev_in;
   logic [SW-1:0]             node_ff, node_in;
   logic [POS_W-1:0]          hops_ff, hops_in;
   logic [STAT_W-1:0]         status_ff, status_in;
   logic signed [VALUE_W-1:0] removed_ff, removed_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_payload_type           rsp_data_ff, rsp_data_in;

   logic               link_we;
   logic [SW-1:0]      link_addr;
   logic [SW-1:0]      link_wdata;
   logic [SW-1:0]      link_rdata;
   logic               elem_we;
   logic [SW-1:0]      elem_addr;
   logic [VALUE_W-1:0] elem_rdata;

   logic [CMPW-1:0] pos_ext;
   logic [CMPW-1:0] cnt_ext;
   logic            ins_ok;
   logic            del_ok;
   logic            reached;

   // Link RAM: next pointer of each slot. Element RAM: the stored values.
   sllm_ram #(
      .DEPTH (LIST_SLOTS),
      .WIDTH (SW)
   ) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .addr  (link_addr),
      .wdata (link_wdata),
      .rdata (link_rdata)
   );

   sllm_ram #(
      .DEPTH (LIST_SLOTS),
      .WIDTH (VALUE_W)
   ) u_elem_ram (
      .clock (clock),
      .we    (elem_we),
      .addr  (elem_addr),
      .wdata (value_ff),
      .rdata (elem_rdata)
   );

   // Position checks against the element counter, done on the incoming item.
   assign pos_ext = CMPW'(req_data.position);
   assign cnt_ext = CMPW'(count_ff);
   assign ins_ok  = (req_data.position != '0) && (pos_ext <= cnt_ext + CMPW'(1));
   assign del_ok  = (req_data.position != '0) && (pos_ext <= cnt_ext);

   // The walk has reached the predecessor once it has made position-1 hops.
   assign reached = (hops_ff == pos_ff - POS_W'(1));

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_cnt_ff  <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_cnt_ff  <= init_cnt_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      pos_ff      <= pos_in;
      value_ff    <= value_in;
      slot_ff     <= slot_in;
      prev_ff     <= prev_in;
      node_ff     <= node_in;
      hops_ff     <= hops_in;
      status_ff   <= status_in;
      removed_ff  <= removed_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      init_cnt_in  = init_cnt_ff;
      count_in     = count_ff;
      kind_in      = kind_ff;
      pos_in       = pos_ff;
      value_in     = value_ff;
      slot_in      = slot_ff;
      prev_in      = prev_ff;
      node_in      = node_ff;
      hops_in      = hops_ff;
      status_in    = status_ff;
      removed_in   = removed_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;

      link_we    = 1'b0;
      link_addr  = FREE_HEAD;
      link_wdata = '0;
      elem_we    = 1'b0;
      elem_addr  = slot_ff;

      case (state_ff)
         ST_INIT: begin
            // Build the free chain 1..LIST_SLOTS-2; both chains end at slot 0.
            link_we    = 1'b1;
            link_addr  = init_cnt_ff;
            link_wdata = (init_cnt_ff >= LAST_ELEM) ? '0 : init_cnt_ff + SW'(1);
            init_cnt_in = init_cnt_ff + SW'(1);
            if (init_cnt_ff == USED_HEAD) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               kind_in    = req_data.kind;
               pos_in     = req_data.position;
               value_in   = req_data.value;
               removed_in = '0;
               status_in  = STAT_DONE;
               if (req_data.kind == KIND_INSERT) begin
                  if (ins_ok) begin
                     link_addr = FREE_HEAD;
                     state_in  = ST_FREE_HEAD;
                  end else begin
                     status_in = STAT_BAD_POS;
                     state_in  = ST_DONE;
                  end
               end else begin
                  if (del_ok) begin
                     state_in = ST_WALK_START;
                  end else begin
                     status_in = STAT_BAD_POS;
                     state_in  = ST_DONE;
                  end
               end
            end
         end

         ST_FREE_HEAD: begin
            // The read data is the first free slot; slot 0 here means full.
            if (link_rdata == FREE_HEAD) begin
               status_in = STAT_FULL;
               state_in  = ST_DONE;
            end else begin
               slot_in   = link_rdata;
               link_addr = link_rdata;
               state_in  = ST_FREE_NEXT;
            end
         end

         ST_FREE_NEXT: begin
            // Pop the taken slot off the free chain.
            link_we    = 1'b1;
            link_addr  = FREE_HEAD;
            link_wdata = link_rdata;
            state_in   = ST_WALK_START;
         end

         ST_WALK_START: begin
            link_addr = USED_HEAD;
            prev_in   = USED_HEAD;
            hops_in   = '0;
            state_in  = ST_WALK;
         end

         ST_WALK: begin
            // The read data is always the successor of prev_ff.
            if (!reached) begin
               prev_in   = link_rdata;
               hops_in   = hops_ff + POS_W'(1);
               link_addr = link_rdata;
            end else begin
               node_in = link_rdata;
               if (kind_ff == KIND_INSERT) begin
                  state_in = ST_INS_LINK;
               end else if ((link_rdata == FREE_HEAD) || (link_rdata == USED_HEAD)) begin
                  status_in = STAT_BAD_POS;
                  state_in  = ST_DONE;
               end else begin
                  link_addr = link_rdata;
                  elem_addr = link_rdata;
                  state_in  = ST_DEL_UNLINK;
               end
            end
         end

         ST_INS_LINK: begin
            link_we    = 1'b1;
            link_addr  = slot_ff;
            link_wdata = node_ff;
            elem_we    = 1'b1;
            elem_addr  = slot_ff;
            state_in   = ST_INS_PREV;
         end

         ST_INS_PREV: begin
            link_we    = 1'b1;
            link_addr  = prev_ff;
            link_wdata = slot_ff;
            count_in   = count_ff + SW'(1);
            state_in   = ST_DONE;
         end

         ST_DEL_UNLINK: begin
            // Bypass the victim: prev now points at the victim's successor.
            removed_in = $signed(elem_rdata);
            link_we    = 1'b1;
            link_addr  = prev_ff;
            link_wdata = link_rdata;
            state_in   = ST_DEL_FREE_RD;
         end

         ST_DEL_FREE_RD: begin
            link_addr = FREE_HEAD;
            state_in  = ST_DEL_FREE_WR;
         end

         ST_DEL_FREE_WR: begin
            link_we    = 1'b1;
            link_addr  = node_ff;
            link_wdata = link_rdata;
            state_in   = ST_DEL_HEAD_WR;
         end

         ST_DEL_HEAD_WR: begin
            link_we    = 1'b1;
            link_addr  = FREE_HEAD;
            link_wdata = node_ff;
            count_in   = count_ff - SW'(1);
            state_in   = ST_DONE;
         end

         ST_DONE: begin
            // Hand the result over once the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.removed_value = removed_ff;
               rsp_data_in.status        = status_ff;
               rsp_data_in.list_length   = LEN_W'(count_ff);
               state_in                  = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== tb/sv/tb_static_linked_list_manager.sv =====
// ----------------------------------------------------------------------------
// Static linked list manager testbench
// Drives insert and delete items and checks every result against a list model.
// ----------------------------------------------------------------------------
// A short table of directed items covers the empty list, rejected positions at
// both ends of the position field, the signed value extremes and removal from
// the head, the middle and the tail. Random items then push the list through
// fill and drain trends, so it reaches the full store and empties again,
// under three idling patterns on the two channels.
// ----------------------------------------------------------------------------
module tb_static_linked_list_manager;
   import sllm_pkg::*;

   localparam int SLOTS           = 64;
   localparam int LAST_SLOT       = SLOTS - 1;
   localparam int ITEMS_PER_PHASE = 600;
   localparam int NUM_DIRECTED    = 22;
   // The settling window is sized for the clearing pass and the longest walk.
   localparam int SETTLE_CYCLES   = SLOTS + 16;
   localparam int STALL_LIMIT     = 2000;

   typedef struct packed {
      bit              typed;
      req_payload_type op;
      rsp_payload_type rsp;
   } directed_row_type;

   logic            clock     = 1'b0;
   logic            reset     = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_data  = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_data;

   // Copy of the list kept by the testbench: link store, value store, length.
   logic [POS_W-1:0]          list_link [SLOTS];
   logic signed [VALUE_W-1:0] list_value [SLOTS];
   int                        list_len;

   // Results still owed by the block, oldest first.
   rsp_payload_type pending_results[$];
   rsp_payload_type oldest;

   int sender_idle_pct = 9;
   int rsp_idle_pct    = 87;
   int fail_count      = 0;
   int stall_cycles    = 0;
   int items_sent      = 0;
   int inserts_done    = 0;
   int deletes_done    = 0;
   int full_hits       = 0;
   int bad_pos_hits    = 0;
   int peak_len        = 0;

   // Directed items. The list contents after some rows are noted at their end;
   // rows with typed cleared take their expected result from the list model.
   directed_row_type directed_rows [NUM_DIRECTED] = '{
      '{1'b1, '{KIND_DELETE, 6'd1,  32'sd0},         '{32'sd0, STAT_BAD_POS, 6'd0}}, // empty
      '{1'b1, '{KIND_INSERT, 6'd0,  32'sd5},         '{32'sd0, STAT_BAD_POS, 6'd0}},
      '{1'b1, '{KIND_INSERT, 6'd2,  32'sd5},         '{32'sd0, STAT_BAD_POS, 6'd0}},
      '{1'b1, '{KIND_INSERT, 6'd63, 32'sd5},         '{32'sd0, STAT_BAD_POS, 6'd0}},
      '{1'b1, '{KIND_INSERT, 6'd1,  32'sh7fffffff},  '{32'sd0, STAT_DONE,    6'd1}}, // MAX
      '{1'b1, '{KIND_INSERT, 6'd1,  32'sh80000000},  '{32'sd0, STAT_DONE,    6'd2}}, // MIN MAX
      '{1'b1, '{KIND_INSERT, 6'd3,  32'shffffffff},  '{32'sd0, STAT_DONE,    6'd3}}, // +(-1)
      '{1'b1, '{KIND_INSERT, 6'd2,  32'sd0},         '{32'sd0, STAT_DONE,    6'd4}}, // MIN 0 MAX -1
      '{1'b1, '{KIND_DELETE, 6'd0,  32'sd0},         '{32'sd0, STAT_BAD_POS, 6'd4}},
      '{1'b1, '{KIND_DELETE, 6'd5,  32'sd0},         '{32'sd0, STAT_BAD_POS, 6'd4}},
      '{1'b1, '{KIND_DELETE, 6'd63, 32'shffffffff},  '{32'sd0, STAT_BAD_POS, 6'd4}},
      '{1'b1, '{KIND_INSERT, 6'd6,  32'sd9},         '{32'sd0, STAT_BAD_POS, 6'd4}},
      '{1'b1, '{KIND_DELETE, 6'd4,  32'sd0},  '{32'shffffffff, STAT_DONE,    6'd3}}, // MIN 0 MAX
      '{1'b1, '{KIND_DELETE, 6'd2,  32'sd0},         '{32'sd0, STAT_DONE,    6'd2}}, // MIN MAX
      '{1'b1, '{KIND_INSERT, 6'd3,  32'sh55555555},  '{32'sd0, STAT_DONE,    6'd3}},
      '{1'b0, '{KIND_INSERT, 6'd2,  32'shaaaaaaaa},  '{32'sd0, STAT_DONE,    6'd0}},
      '{1'b1, '{KIND_DELETE, 6'd1,  32'sd0},  '{32'sh80000000, STAT_DONE,    6'd3}},
      '{1'b1, '{KIND_DELETE, 6'd1,  32'sd0},  '{32'shaaaaaaaa, STAT_DONE,    6'd2}},
      '{1'b1, '{KIND_DELETE, 6'd2,  32'sd0},  '{32'sh55555555, STAT_DONE,    6'd1}},
      '{1'b1, '{KIND_DELETE, 6'd1,  32'sd0},  '{32'sh7fffffff, STAT_DONE,    6'd0}}, // empty
      '{1'b1, '{KIND_DELETE, 6'd1,  32'sd0},         '{32'sd0, STAT_BAD_POS, 6'd0}},
      '{1'b0, '{KIND_INSERT, 6'd1,  32'sh12345678},  '{32'sd0, STAT_DONE,    6'd0}}
   };

   static_linked_list_manager #(
      .LIST_SLOTS(SLOTS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always #2 clock = ~clock;

   // Applies one operation to the model list and returns the result the block
   // owes for it. The free chain hangs off slot 0 and the used chain off the
   // last slot, exactly as in the block, so slot reuse order is modeled too.
   function automatic rsp_payload_type predict_list_op(req_payload_type op);
      rsp_payload_type  outcome;
      logic [POS_W-1:0] prev;
      logic [POS_W-1:0] slot;
      outcome = '0;
      // Find the element just ahead of the position. For a rejected position
      // this walk only reads, so running it unconditionally is harmless.
      prev = POS_W'(LAST_SLOT);
      for (int n = 1; n < op.position; n++) prev = list_link[prev];
      if (op.kind == KIND_INSERT) begin
         if (op.position == 0 || op.position > list_len + 1) begin
            outcome.status = STAT_BAD_POS;
            bad_pos_hits++;
         end else if (list_link[0] == 0) begin
            // The position check comes first; only a good position reports full.
            outcome.status = STAT_FULL;
            full_hits++;
         end else begin
            slot             = list_link[0];
            list_link[0]     = list_link[slot];
            list_value[slot] = op.value;
            list_link[slot]  = list_link[prev];
            list_link[prev]  = slot;
            list_len++;
            inserts_done++;
         end
      end else begin
         if (op.position == 0 || op.position > list_len) begin
            outcome.status = STAT_BAD_POS;
            bad_pos_hits++;
         end else begin
            slot                  = list_link[prev];
            outcome.removed_value = list_value[slot];
            list_link[prev]       = list_link[slot];
            list_link[slot]       = list_link[0];
            list_link[0]          = slot;
            list_len--;
            deletes_done++;
         end
      end
      if (list_len > peak_len) peak_len = list_len;
      outcome.list_length = LEN_W'(list_len);
      return outcome;
   endfunction

   // Presents one item, holds it until the block takes it, then records the
   // expected result. Valid is left high on return so that a following item
   // with no gap goes out back to back; only a gap lowers it.
   task automatic send_op(input req_payload_type op, input bit typed,
                          input rsp_payload_type typed_rsp);
      rsp_payload_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_data  <= op;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predicted = predict_list_op(op);
      pending_results.push_back(typed ? typed_rsp : predicted);
      items_sent++;
   endtask

   // Lowers valid and holds the sender back until every owed result is back.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Result side: random ready, and a field by field check of each result
   // taken against the oldest expectation.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      if (rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("Result with no item outstanding: removed_value %0d status %0d length %0d",
                   rsp_data.removed_value, rsp_data.status, rsp_data.list_length);
            fail_count++;
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_data.removed_value !== oldest.removed_value) begin
               $error("removed_value: expected %0d, actual %0d",
                      oldest.removed_value, rsp_data.removed_value);
               fail_count++;
            end
            if (rsp_data.status !== oldest.status) begin
               $error("status: expected %0d, actual %0d", oldest.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.list_length !== oldest.list_length) begin
               $error("list_length: expected %0d, actual %0d",
                      oldest.list_length, rsp_data.list_length);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: a long stretch with no item moving on either channel means the
   // block has hung. The limit covers the clearing pass and the longest walk
   // plus a long run of receiver stalls with a wide margin.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin : stimulus
      req_payload_type op;
      int              trend;
      int              insert_pct;

      // Model list after reset: free chain 1..SLOTS-2, used chain empty.
      for (int i = 0; i < SLOTS; i++) begin
         list_link[i]  = POS_W'(i + 1);
         list_value[i] = '0;
      end
      list_link[SLOTS-2] = '0;
      list_link[SLOTS-1] = '0;
      list_len = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed rows run under the first idling pattern. The block holds
      // req_ready low through its clearing pass, so the first item waits.
      foreach (directed_rows[i]) begin
         send_op(directed_rows[i].op, directed_rows[i].typed, directed_rows[i].rsp);
      end
      wait_for_drain();

      // Three phases of random items: sender rarely idle with a slow
      // receiver, then the reverse, then both sides at full rate. Within a
      // phase the mix runs twice from mostly inserts (reaching the full store)
      // through an even mix to mostly deletes (emptying the list again).
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct = 9;
               rsp_idle_pct   <= 87;
            end
            1: begin
               sender_idle_pct = 87;
               rsp_idle_pct   <= 9;
            end
            default: begin
               sender_idle_pct = 0;
               rsp_idle_pct   <= 0;
            end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            trend      = (n / 100) % 3;
            insert_pct = (trend == 0) ? 90 : (trend == 1) ? 50 : 10;
            op.kind    = ($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_DELETE;
            op.value   = $urandom();
            // Most positions are legal for the current length; one in ten is
            // any value of the field, which mostly lands out of range.
            if ($urandom_range(9) == 0 || (op.kind == KIND_DELETE && list_len == 0)) begin
               op.position = POS_W'($urandom_range(63));
            end else if (op.kind == KIND_INSERT) begin
               op.position = POS_W'($urandom_range(list_len + 1, 1));
            end else begin
               op.position = POS_W'($urandom_range(list_len, 1));
            end
            send_op(op, 1'b0, '0);
         end
         wait_for_drain();
      end

      // Any stray result in this window is caught by the result check.
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Ran %0d items: %0d inserts and %0d deletes done, %0d full-store rejects,",
               items_sent, inserts_done, deletes_done, full_hits);
      $display("%0d bad positions, longest list %0d elements.", bad_pos_hits, peak_len);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== static_linked_list_manager.f =====
hdl/sllm_pkg.sv
hdl/sllm_ram.sv
hdl/static_linked_list_manager.sv
tb/sv/tb_static_linked_list_manager.sv
